FILE: rtl/core/b64c_pkg.sv
// Shared types, codes and alphabet functions of the Base64 codec.
package b64c_pkg;

   // Number of result words one input word can cause at most.
   localparam int unsigned MaxWords = 4;
   localparam int unsigned CountWidth = $clog2(MaxWords + 1);

   // Characters with a special meaning in the alphabet.
   localparam logic [7:0] CharPad   = 8'h3d;  // '='
   localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
   localparam logic [7:0] CharSlash = 8'h2f;  // '/'
   localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
   localparam logic [7:0] CharUpZ   = 8'h5a;  // 'Z'
   localparam logic [7:0] CharLoA   = 8'h61;  // 'a'
   localparam logic [7:0] CharLoZ   = 8'h7a;  // 'z'
   localparam logic [7:0] CharZero  = 8'h30;  // '0'
   localparam logic [7:0] CharNine  = 8'h39;  // '9'

   // Sextet values where the alphabet changes range.
   localparam logic [5:0] ValLoStart    = 6'd26;
   localparam logic [5:0] ValDigitStart = 6'd52;
   localparam logic [5:0] ValPlus       = 6'd62;
   localparam logic [5:0] ValSlash      = 6'd63;

   // Direction register values.
   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_CHAR   = 2'd1,
      ST_BAD_LENGTH = 2'd2,
      ST_BAD_PAD    = 2'd3
   } status_type;

   // Stream state carried from one input word to the next.
   typedef struct packed {
      logic [1:0]  group_position;
      logic [17:0] bit_holder;
      logic [1:0]  pad_count;
      logic        discarding;
   } state_type;

   // One result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      status_type status;
   } word_type;

   // All result words caused by one input word; word 0 goes out first.
   typedef struct packed {
      word_type [MaxWords-1:0]  words;
      logic [CountWidth-1:0]    count;
   } batch_type;

   // Decoded value of one alphabet character.
   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Alphabet character for a six-bit value.
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] ext;
      ext = {2'b00, v};
      if (v < ValLoStart) begin
         return CharUpA + ext;
      end else if (v < ValDigitStart) begin
         return CharLoA + ext - {2'b00, ValLoStart};
      end else if (v < ValPlus) begin
         return CharZero + ext - {2'b00, ValDigitStart};
      end else if (v == ValPlus) begin
         return CharPlus;
      end else begin
         return CharSlash;
      end
   endfunction

   // Six-bit value of an alphabet character, with a flag for membership.
   function automatic sextet_type b64_value(input logic [7:0] ch);
      sextet_type r;
      r.ok = 1'b1;
      r.value = '0;
      if (ch >= CharUpA && ch <= CharUpZ) begin
         r.value = 6'(ch - CharUpA);
      end else if (ch >= CharLoA && ch <= CharLoZ) begin
         r.value = 6'(ch - CharLoA + {2'b00, ValLoStart});
      end else if (ch >= CharZero && ch <= CharNine) begin
         r.value = 6'(ch - CharZero + {2'b00, ValDigitStart});
      end else if (ch == CharPlus) begin
         r.value = ValPlus;
      end else if (ch == CharSlash) begin
         r.value = ValSlash;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/b64c_if.sv
// Valid/ready channel interfaces for the input and result words of the codec.

interface b64c_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface

FILE: rtl/core/base64_codec_unit.sv
// Top level of the Base64 codec: input register, step logic and result buffer.
//
//   channel   direction  payload                       handshake
//   req_if    in         in_byte[7:0], in_last         valid / ready
//   rsp_if    out        out_byte[7:0], out_last,      valid / ready
//                        status[1:0]
//   csr_*     in         csr_wdata (direction)         csr_we, no wait
//
// Each accepted word is worked by the combinational step between the input register and
// the result buffer; its results reach rsp_if once the buffer has loaded them.
// The buffer sends one result word per cycle while rsp_if is ready, so an encoded
// group of three bytes gives four words, a decoded group of four characters up to three.
// Reset clears the direction (encode) and all stream state. A stalled
// result side holds the buffer and the input register, then the input side.
module base64_codec_unit (
   input  logic         clock,
   input  logic         reset,
   b64c_req_if.sink     req_if,
   b64c_rsp_if.source   rsp_if,
   input  logic         csr_we,
   input  logic         csr_wdata
);
   import b64c_pkg::*;

   logic       dir_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   state_type  state_ff;
   state_type  state_in;
   batch_type  batch;
   logic       buf_free;
   logic       consume;
   logic       load;
   logic       accept;

   // Step logic on the registered input word.
   b64c_step u_step (
      .dir      (dir_ff),
      .state    (state_ff),
      .in_byte  (in_byte_ff),
      .in_last  (in_last_ff),
      .state_in (state_in),
      .batch    (batch)
   );

   // Result buffer toward the result channel.
   b64c_out_buf u_out_buf (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .batch  (batch),
      .free   (buf_free),
      .rsp_if (rsp_if)
   );

   // A held word retires when its results fit into the buffer.
   assign consume = in_valid_ff && ((batch.count == '0) || buf_free);
   assign load = consume && (batch.count != '0);
   assign req_if.ready = !in_valid_ff || consume;
   assign accept = req_if.valid && req_if.ready;
   assign in_valid_in = accept || (in_valid_ff && !consume);

   // Control registers: direction, input valid and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DirEncode;
         in_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            dir_ff <= csr_wdata;
            state_ff <= '0;
         end else if (consume) begin
            state_ff <= state_in;
         end
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_if.in_byte;
         in_last_ff <= req_if.in_last;
      end
   end

`ifndef ASSERT_OFF
   // A batch only enters a buffer that is empty or about to be.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> buf_free)
      else $error("result batch loaded over pending words");

   // The end of a message leaves no stream state behind.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (consume && in_last_ff && !csr_we) |=> (state_ff == '0))
      else $error("stream state left after end of message");

   // Encoding never reports an error.
   a_enc_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && dir_ff == DirEncode) |-> (rsp_if.status == ST_OK))
      else $error("error status while encoding");

   // A word waiting in the input register with a full buffer stays put.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !consume) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input word lost while stalled");
`endif

endmodule

FILE: rtl/core/b64c_step.sv
// Combinational encode and decode step: one input word against the stream state.
module b64c_step (
   input  logic                 dir,
   input  b64c_pkg::state_type  state,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output b64c_pkg::state_type  state_in,
   output b64c_pkg::batch_type  batch
);
   import b64c_pkg::*;

   // Encoder operands.
   logic [7:0]  enc_a;
   logic [7:0]  enc_c;
   logic [7:0]  enc_d;
   logic [7:0]  enc_ch2;
   logic [7:0]  enc_ch3;

   // Decoder operands.
   sextet_type  dec_sx;
   logic        dec_is_pad;
   logic [5:0]  dec_v;
   logic [1:0]  dec_pad_next;
   logic [23:0] dec_w;
   logic        dec_err;
   status_type  dec_code;

   // Pick the bytes of the group that the encoder works on.
   always_comb begin
      enc_a = in_byte;
      enc_c = '0;
      enc_d = '0;
      case (state.group_position)
         2'd0: begin
            enc_a = in_byte;
         end
         2'd1: begin
            enc_a = state.bit_holder[7:0];
            enc_c = in_byte;
         end
         default: begin
            enc_a = state.bit_holder[15:8];
            enc_c = state.bit_holder[7:0];
            enc_d = in_byte;
         end
      endcase
      enc_ch2 = (state.group_position == 2'd0) ? CharPad :
                b64_char({enc_c[3:0], enc_d[7:6]});
      enc_ch3 = (state.group_position >= 2'd2) ? b64_char(enc_d[5:0]) : CharPad;
   end

   // Classify the decoder character and find the first error that applies.
   always_comb begin
      dec_sx = b64_value(in_byte);
      dec_is_pad = (in_byte == CharPad);
      dec_v = dec_is_pad ? 6'd0 : dec_sx.value;
      dec_pad_next = state.pad_count + {1'b0, dec_is_pad};
      dec_w = {state.bit_holder, dec_v};
      dec_err = 1'b1;
      if (state.pad_count != 2'd0 && state.group_position == 2'd0) begin
         dec_code = ST_BAD_PAD;
      end else if (dec_is_pad && state.group_position < 2'd2) begin
         dec_code = ST_BAD_PAD;
      end else if (!dec_is_pad && !dec_sx.ok) begin
         dec_code = ST_BAD_CHAR;
      end else if (!dec_is_pad && state.pad_count != 2'd0) begin
         dec_code = ST_BAD_PAD;
      end else if (state.group_position < 2'd3 && in_last) begin
         dec_code = ST_BAD_LENGTH;
      end else begin
         dec_code = ST_OK;
         dec_err = 1'b0;
      end
   end

   // Next state and result words.
   always_comb begin
      state_in = state;
      batch = '0;
      if (dir == DirEncode) begin
         if (!in_last && state.group_position < 2'd2) begin
            // Gather one more byte of the group.
            state_in.bit_holder = {2'b00, state.bit_holder[7:0], in_byte};
            state_in.group_position = state.group_position + 2'd1;
         end else begin
            // Full group, or a short group flushed at the end of the message.
            batch.words[0] = '{b64_char(enc_a[7:2]), 1'b0, ST_OK};
            batch.words[1] = '{b64_char({enc_a[1:0], enc_c[7:4]}), 1'b0, ST_OK};
            batch.words[2] = '{enc_ch2, 1'b0, ST_OK};
            batch.words[3] = '{enc_ch3, in_last, ST_OK};
            batch.count = CountWidth'(MaxWords);
            state_in = '0;
         end
      end else if (state.discarding) begin
         // Drop words until the end of the message.
         if (in_last) begin
            state_in = '0;
         end
      end else if (dec_err) begin
         batch.words[0] = '{8'd0, in_last, dec_code};
         batch.count = CountWidth'(1);
         state_in = '0;
         state_in.discarding = !in_last;
      end else if (state.group_position < 2'd3) begin
         state_in.bit_holder = {state.bit_holder[11:0], dec_v};
         state_in.group_position = state.group_position + 2'd1;
         state_in.pad_count = dec_pad_next;
      end else begin
         // Fourth character: emit three bytes less the padding.
         batch.words[0] = '{dec_w[23:16], in_last && dec_pad_next == 2'd2, ST_OK};
         batch.words[1] = '{dec_w[15:8], in_last && dec_pad_next == 2'd1, ST_OK};
         batch.words[2] = '{dec_w[7:0], in_last, ST_OK};
         batch.count = CountWidth'(2'd3 - dec_pad_next);
         state_in.group_position = 2'd0;
         state_in.bit_holder = '0;
         state_in.pad_count = in_last ? 2'd0 : dec_pad_next;
         state_in.discarding = 1'b0;
      end
   end

endmodule

FILE: rtl/core/b64c_out_buf.sv
// Result buffer: holds the words of one input word and sends them one per cycle while rsp_if is ready.
module b64c_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  b64c_pkg::batch_type batch,
   output logic                free,
   b64c_rsp_if.source          rsp_if
);
   import b64c_pkg::*;

   word_type [MaxWords-1:0] words_ff;
   word_type [MaxWords-1:0] words_in;
   logic [CountWidth-1:0]   rem_ff;
   logic [CountWidth-1:0]   rem_in;
   logic                    take;

   // A new batch may enter once the last held word leaves.
   assign take = rsp_if.valid && rsp_if.ready;
   assign free = (rem_ff == '0) || (rem_ff == CountWidth'(1) && rsp_if.ready);

   // Load a batch or shift the next word to the front.
   always_comb begin
      words_in = words_ff;
      rem_in = rem_ff;
      if (load) begin
         words_in = batch.words;
         rem_in = batch.count;
      end else if (take) begin
         for (int i = 0; i < MaxWords - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         rem_in = rem_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   // Front word drives the channel.
   assign rsp_if.valid = (rem_ff != '0);
   assign rsp_if.out_byte = words_ff[0].out_byte;
   assign rsp_if.out_last = words_ff[0].out_last;
   assign rsp_if.status = words_ff[0].status;

endmodule

FILE: tb/sv/base64_codec_checker.sv
// Checker for the Base64 codec: predicts result words and compares them as they leave.
module base64_codec_checker (
   input  logic  clock,
   input  logic  reset,
   b64c_req_if   req_mon,
   b64c_rsp_if   rsp_mon,
   input  logic  csr_we,
   input  logic  csr_wdata,
   output int    fail_count,
   output int    pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import b64c_pkg::*;

   // Alphabet in sextet order, first character in the top byte.
   localparam logic [511:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int ReportLimit = 10;

   // Predicted codec state and direction.
   logic        dir_decode;
   logic [1:0]  grp_pos;
   logic [17:0] held_bits;
   logic [1:0]  pad_seen;
   logic        dropping;

   word_type expected_words[$];
   int       mismatches = 0;
   int       words_seen = 0;

   assign fail_count = mismatches;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return Alphabet[511 - 8 * int'(v) -: 8];
   endfunction

   // Returns the sextet of an alphabet character, or -1 when it is not one.
   function automatic int char_to_sextet(input logic [7:0] ch);
      for (int i = 0; i < 64; i++) begin
         if (Alphabet[511 - 8 * i -: 8] == ch) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void clear_stream();
      grp_pos   = '0;
      held_bits = '0;
      pad_seen  = '0;
      dropping  = 1'b0;
   endfunction

   function automatic void expect_word(input logic [7:0] b, input logic l,
                                       input status_type s);
      word_type w;
      w.out_byte = b;
      w.out_last = l;
      w.status   = s;
      expected_words.push_back(w);
   endfunction

   // Encoding collects three bytes, or flushes a padded partial group on the last byte.
   function automatic void encode_byte(input logic [7:0] b, input logic l);
      logic [7:0] a;
      logic [7:0] c;
      case (grp_pos)
         2'd0: begin
            if (!l) begin
               held_bits = {10'b0, b};
               grp_pos   = 2'd1;
               return;
            end
            expect_word(sextet_char(b[7:2]), 1'b0, ST_OK);
            expect_word(sextet_char({b[1:0], 4'b0}), 1'b0, ST_OK);
            expect_word(CharPad, 1'b0, ST_OK);
            expect_word(CharPad, 1'b1, ST_OK);
         end
         2'd1: begin
            a = held_bits[7:0];
            if (!l) begin
               held_bits = {2'b0, a, b};
               grp_pos   = 2'd2;
               return;
            end
            expect_word(sextet_char(a[7:2]), 1'b0, ST_OK);
            expect_word(sextet_char({a[1:0], b[7:4]}), 1'b0, ST_OK);
            expect_word(sextet_char({b[3:0], 2'b0}), 1'b0, ST_OK);
            expect_word(CharPad, 1'b1, ST_OK);
         end
         default: begin
            a = held_bits[15:8];
            c = held_bits[7:0];
            expect_word(sextet_char(a[7:2]), 1'b0, ST_OK);
            expect_word(sextet_char({a[1:0], c[7:4]}), 1'b0, ST_OK);
            expect_word(sextet_char({c[3:0], b[7:6]}), 1'b0, ST_OK);
            expect_word(sextet_char(b[5:0]), l, ST_OK);
         end
      endcase
      clear_stream();
   endfunction

   // A decode error gives one zero word and drops the rest of the message.
   function automatic void report_error(input status_type s, input logic l);
      expect_word(8'h00, l, s);
      clear_stream();
      dropping = !l;
   endfunction

   function automatic void decode_char(input logic [7:0] ch, input logic l);
      int          m;
      int          n;
      logic [5:0]  v;
      logic [23:0] w;
      if (dropping) begin
         if (l) begin
            clear_stream();
         end
         return;
      end
      // Anything following a padded group is a padding error.
      if (pad_seen != 0 && grp_pos == 0) begin
         report_error(ST_BAD_PAD, l);
         return;
      end
      m = char_to_sextet(ch);
      v = '0;
      if (ch == CharPad) begin
         if (grp_pos < 2) begin
            report_error(ST_BAD_PAD, l);
            return;
         end
         pad_seen = pad_seen + 2'd1;
      end else if (m < 0) begin
         report_error(ST_BAD_CHAR, l);
         return;
      end else if (pad_seen != 0) begin
         report_error(ST_BAD_PAD, l);
         return;
      end else begin
         v = 6'(m);
      end
      if (grp_pos < 3) begin
         if (l) begin
            report_error(ST_BAD_LENGTH, l);
            return;
         end
         held_bits = {held_bits[11:0], v};
         grp_pos   = grp_pos + 2'd1;
         return;
      end
      // Fourth character: padding shortens the group to two or one bytes.
      w = {held_bits, v};
      n = 3 - int'(pad_seen);
      for (int k = 0; k < n; k++) begin
         expect_word(w[23 - 8 * k -: 8], (k == n - 1) ? l : 1'b0, ST_OK);
      end
      grp_pos   = '0;
      held_bits = '0;
      if (l) begin
         clear_stream();
      end
   endfunction

   function automatic void check_word();
      word_type seen;
      word_type want;
      seen.out_byte = rsp_mon.out_byte;
      seen.out_last = rsp_mon.out_last;
      seen.status   = status_type'(rsp_mon.status);
      words_seen++;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= ReportLimit) begin
            $display("result word %0d arrived with none expected: %s %h last %b status %0d",
                     words_seen, "byte", seen.out_byte, seen.out_last, seen.status);
         end
         return;
      end
      want = expected_words.pop_front();
      if (seen.out_byte !== want.out_byte || seen.out_last !== want.out_last ||
          seen.status !== want.status) begin
         mismatches++;
         if (mismatches <= ReportLimit) begin
            $display("result word %0d: expected byte %h last %b status %0d,",
                     words_seen, want.out_byte, want.out_last, want.status);
            $display("   got byte %h last %b status %0d",
                     seen.out_byte, seen.out_last, seen.status);
         end
      end
   endfunction

   // Result words are checked before new input words are predicted at each edge.
   always @(posedge clock) begin
      if (reset) begin
         dir_decode = DirEncode;
         clear_stream();
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_word();
         end
         if (csr_we) begin
            dir_decode = csr_wdata;
            clear_stream();
         end
         if (req_mon.valid && req_mon.ready) begin
            if (dir_decode == DirDecode) begin
               decode_char(req_mon.in_byte, req_mon.in_last);
            end else begin
               encode_byte(req_mon.in_byte, req_mon.in_last);
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

FILE: tb/sv/base64_codec_unit_test.sv
// Testbench top for the Base64 codec: clock, reset, stimulus, receiver stalls and verdict.
module base64_codec_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import b64c_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int HoldCycles    = 400;
   localparam int SettleCycles  = 16;
   localparam int WordsPerHalf  = 32;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   int   fail_count;
   int   pending_words;
   int   cycle_count = 0;

   // Idle percentages of the current phase and the long receiver hold request.
   int   sender_idle_pct = 0;
   int   stall_pct = 0;
   bit   hold_go = 1'b0;
   int   hold_left = 0;

   logic [7:0] message_bytes[$];

   b64c_req_if req_chan();
   b64c_rsp_if rsp_chan();

   base64_codec_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   base64_codec_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, or a long counted hold when one is requested.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HoldCycles;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offers one word after a random gap and returns at the edge that accepts it.
   task automatic send_word(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= l;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // Sends the queued message; the last word is marked when the message closes.
   task automatic send_message(input bit close);
      for (int i = 0; i < message_bytes.size(); i++) begin
         send_word(message_bytes[i], close && (i == message_bytes.size() - 1));
      end
   endtask

   task automatic send_string(input string s, input bit close);
      message_bytes.delete();
      for (int i = 0; i < s.len(); i++) begin
         message_bytes.push_back(s[i]);
      end
      send_message(close);
   endtask

   task automatic send_bytes(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input int count);
      message_bytes.delete();
      message_bytes.push_back(a);
      if (count > 1) begin
         message_bytes.push_back(b);
      end
      if (count > 2) begin
         message_bytes.push_back(c);
      end
      send_message(1'b1);
   endtask

   // Pauses the sender until every expected word is out, then lets the pipe settle.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      csr_we    <= 1'b1;
      csr_wdata <= dir;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] random_alphabet_char();
      int v;
      v = $urandom_range(63);
      if (v < 26) begin
         return 8'(CharUpA + v);
      end else if (v < 52) begin
         return 8'(CharLoA + v - 26);
      end else if (v < 62) begin
         return 8'(CharZero + v - 52);
      end else if (v == 62) begin
         return CharPlus;
      end
      return CharSlash;
   endfunction

   // Well-formed Base64 text, sometimes damaged in one place.
   task automatic make_text_message();
      int groups;
      int pads;
      int damage;
      groups = $urandom_range(1, 3);
      pads   = $urandom_range(2);
      damage = $urandom_range(11);
      message_bytes.delete();
      for (int g = 0; g < groups; g++) begin
         for (int i = 0; i < 4; i++) begin
            if (g == groups - 1 && i >= 4 - pads) begin
               message_bytes.push_back(CharPad);
            end else begin
               message_bytes.push_back(random_alphabet_char());
            end
         end
      end
      case (damage)
         8:  message_bytes[$urandom_range(message_bytes.size() - 1)] = 8'($urandom_range(255));
         9:  void'(message_bytes.pop_back());
         10: message_bytes.insert($urandom_range(message_bytes.size() - 1), CharPad);
         11: message_bytes.push_back(random_alphabet_char());
         default: ;
      endcase
   endtask

   // Random bytes, with padding characters made more likely.
   task automatic make_noise_message();
      int len;
      len = $urandom_range(1, 6);
      message_bytes.delete();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(3) == 0) begin
            message_bytes.push_back(CharPad);
         end else begin
            message_bytes.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic make_data_message();
      int len;
      len = $urandom_range(1, 10);
      message_bytes.delete();
      for (int i = 0; i < len; i++) begin
         message_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_half(input bit decoding);
      int sent;
      sent = 0;
      while (sent < WordsPerHalf) begin
         if (!decoding) begin
            make_data_message();
         end else if ($urandom_range(99) < 85) begin
            make_text_message();
         end else begin
            make_noise_message();
         end
         if ($urandom_range(9) == 0) begin
            wait_for_results();
         end
         send_message(1'b1);
         sent += message_bytes.size();
      end
   endtask

   // Main sequence: directed messages, then four idling phases of random messages.
   initial begin
      int sender_phase[4];
      int stall_phase[4];
      sender_phase = '{0, 69, 0, 21};
      stall_phase  = '{0, 0, 69, 21};
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= 1'b0;
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.in_last <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Encoding flushes after one, two and three bytes at the byte extremes.
      write_direction(DirEncode);
      send_bytes(8'h00, 8'h00, 8'h00, 1);
      send_bytes(8'hff, 8'h00, 8'h00, 2);
      send_bytes(8'hff, 8'hff, 8'hff, 3);
      wait_for_results();

      // Decoding: clean group, short message, early padding with discarding,
      // invalid character, character after padding, and text after a padded group.
      write_direction(DirDecode);
      send_string("+/9z", 1'b1);
      send_string("A", 1'b1);
      send_string("A=", 1'b0);
      send_string("Q", 1'b1);
      send_string("*", 1'b1);
      send_string("AB=C", 1'b1);
      send_string("Ax==", 1'b0);
      send_string("Q", 1'b1);

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = sender_phase[p];
         stall_pct = stall_phase[p];
         for (int h = 0; h < 2; h++) begin
            wait_for_results();
            write_direction(h == 1 ? DirDecode : DirEncode);
            if (p == 0 && h == 1) begin
               hold_go = 1'b1;
            end
            run_random_half(h == 1);
         end
      end

      wait_for_results();
      if (fail_count == 0 && pending_words == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
